// ===== design/utf8_validate_repair_defines.svh =====
// ----------------------------------------------------------------------------
// utf8_validate_repair_defines - assertion macros
// shared concurrent assertion forms used by the checker
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDATE_REPAIR_DEFINES_SVH
`define UTF8_VALIDATE_REPAIR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UVR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define UVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/uvr_pkg.sv =====
// ----------------------------------------------------------------------------
// uvr_pkg - shared types and constants
// command format between front and back, utf-8 limits and the U+FFFD bytes
// ----------------------------------------------------------------------------
package uvr_pkg;

    // bytes of U+FFFD in utf-8
    localparam logic [7:0] FFFD_B0 = 8'hEF;
    localparam logic [7:0] FFFD_B1 = 8'hBF;
    localparam logic [7:0] FFFD_B2 = 8'hBD;

    // lead byte masks and patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_VAL   = 8'h80;

    // code point limits
    localparam logic [20:0] MIN_CP2 = 21'h00080;
    localparam logic [20:0] MIN_CP3 = 21'h00800;
    localparam logic [20:0] MIN_CP4 = 21'h10000;
    localparam logic [20:0] MAX_CP  = 21'h10FFFF;
    localparam logic [20:0] SURR_LO = 21'h0D800;
    localparam logic [20:0] SURR_HI = 21'h0DFFF;

    // one command: some U+FFFD tokens, then some raw bytes
    typedef struct packed {
        logic [2:0]      fffd_cnt;
        logic [2:0]      raw_cnt;
        logic [3:0][7:0] raw_bytes;
        logic            str_last;
    } t_cmd;

endpackage

// ===== design/uvr_in_if.sv =====
// ----------------------------------------------------------------------------
// uvr_in_if - raw byte channel
// valid/ready channel carrying one raw byte and its end-of-string flag
// ----------------------------------------------------------------------------
interface uvr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== design/uvr_out_if.sv =====
// ----------------------------------------------------------------------------
// uvr_out_if - repaired byte channel
// valid/ready channel carrying one output byte and its status flags
// ----------------------------------------------------------------------------
interface uvr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       string_end;
    logic       is_substitute;
    logic       any_replaced;

    modport source (output valid, output out_byte, output out_last, output string_end,
                    output is_substitute, output any_replaced, input ready);
    modport sink   (input valid, input out_byte, input out_last, input string_end,
                    input is_substitute, input any_replaced, output ready);
endinterface

// ===== design/utf8_validate_repair.sv =====
// ----------------------------------------------------------------------------
// utf8_validate_repair - streaming utf-8 validator and repairer
// passes well-formed utf-8 and replaces broken sequences with U+FFFD
// ----------------------------------------------------------------------------
// usage:
//   i_in takes one raw byte per request, with in_last on the final byte of a
//   string. o_out gives repaired bytes, each with out_last on the last byte
//   caused by a request, string_end on the final byte of the string,
//   is_substitute on bytes of an inserted U+FFFD and the sticky any_replaced.
//   the first output byte of a request passes through the command queue
//   and then the output register of the expander before it is valid. lead
//   and continuation bytes of an unfinished sequence give no output until
//   the sequence completes or breaks.
//   throughput while ready is high: one output byte per cycle from the
//   expander's single output register; a request of N output bytes (up to
//   12) holds it until all are taken. plain ascii: one request per cycle.
//   the scanner accepts a request whenever the command queue has room
//   (QUEUE_DEPTH commands), so it keeps accepting while the output stalls.
//   reset clears held sequence, queue, output valid and the sticky flag.
//   when the receiver drops ready the output byte holds and the queue fills.
// ----------------------------------------------------------------------------
module utf8_validate_repair #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uvr_in_if.sink    i_in,
    uvr_out_if.source o_out
);
    import uvr_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // scanner
    uvr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // command queue
    uvr_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (full),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_head     (head_cmd)
    );

    // expander
    uvr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== design/uvr_front.sv =====
// ----------------------------------------------------------------------------
// uvr_front - sequence scanner
// holds an unfinished sequence, classifies each byte, issues commands
// ----------------------------------------------------------------------------
module uvr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uvr_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output uvr_pkg::t_cmd o_cmd
);
    import uvr_pkg::*;

    logic [7:0]  r_pend [3];
    logic [1:0]  r_pc;
    logic [1:0]  r_need;
    logic [20:0] r_acc;

    logic [1:0]  n_pc;
    logic [1:0]  n_need;
    logic [20:0] n_acc;

    logic        fire;
    logic [7:0]  b;
    logic        is_cont;
    logic [20:0] acc_c;
    logic        do_start;
    logic        pend_we;
    logic [1:0]  pend_idx;
    logic [2:0]  fffd;
    logic [2:0]  raw_cnt;
    logic [1:0]  pc_eff;

    // range checks on a completed code point
    function automatic logic value_ok(input logic [1:0] need, input logic [20:0] cp);
        logic ok;
        ok = 1'b1;
        if (need == 2'd1 && cp < MIN_CP2) ok = 1'b0;
        if (need == 2'd2 && cp < MIN_CP3) ok = 1'b0;
        if (need == 2'd3 && cp < MIN_CP4) ok = 1'b0;
        if (cp > MAX_CP) ok = 1'b0;
        if (cp >= SURR_LO && cp <= SURR_HI) ok = 1'b0;
        return ok;
    endfunction

    assign fire       = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;
    assign is_cont    = (b & CONT_MASK) == CONT_VAL;
    assign acc_c      = {r_acc[14:0], b[5:0]};
    assign i_in.ready = !i_full;

    // next state and command for the incoming byte
    always_comb begin
        n_pc     = r_pc;
        n_need   = r_need;
        n_acc    = r_acc;
        pend_we  = 1'b0;
        pend_idx = r_pc;
        fffd     = 3'd0;
        raw_cnt  = 3'd0;
        pc_eff   = 2'd0;
        do_start = 1'b0;

        if (r_pc == 2'd0) begin
            do_start = 1'b1;
        end else if (!is_cont) begin
            // broken sequence: one substitute per held byte
            fffd     = {1'b0, r_pc};
            do_start = 1'b1;
        end else if (r_pc >= r_need) begin
            n_pc   = 2'd0;
            n_need = 2'd0;
            n_acc  = '0;
            if (value_ok(r_need, acc_c)) begin
                raw_cnt = {1'b0, r_pc} + 3'd1;
                pc_eff  = r_pc;
            end else begin
                fffd = {1'b0, r_pc} + 3'd1;
            end
        end else begin
            pend_we  = 1'b1;
            pend_idx = r_pc;
            n_pc     = r_pc + 2'd1;
            n_acc    = acc_c;
        end

        // scan the byte as a new start
        if (do_start) begin
            n_pc   = 2'd0;
            n_need = 2'd0;
            n_acc  = '0;
            priority if (!b[7]) begin
                raw_cnt = 3'd1;
            end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
                pend_we  = 1'b1;
                pend_idx = 2'd0;
                n_pc     = 2'd1;
                n_need   = 2'd1;
                n_acc    = {16'd0, b[4:0]};
            end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
                pend_we  = 1'b1;
                pend_idx = 2'd0;
                n_pc     = 2'd1;
                n_need   = 2'd2;
                n_acc    = {17'd0, b[3:0]};
            end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
                pend_we  = 1'b1;
                pend_idx = 2'd0;
                n_pc     = 2'd1;
                n_need   = 2'd3;
                n_acc    = {18'd0, b[2:0]};
            end else begin
                fffd = fffd + 3'd1;
            end
        end

        // end of string flushes whatever is still held
        if (i_in.in_last) begin
            fffd   = fffd + {1'b0, n_pc};
            n_pc   = 2'd0;
            n_need = 2'd0;
            n_acc  = '0;
        end
    end

    // command payload
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_cmd.raw_bytes[i] = (2'(i) < pc_eff) ? r_pend[i] : b;
        end
        o_cmd.raw_bytes[3] = b;
        o_cmd.fffd_cnt     = fffd;
        o_cmd.raw_cnt      = raw_cnt;
        o_cmd.str_last     = i_in.in_last;
    end

    assign o_push = fire && (fffd != 3'd0 || raw_cnt != 3'd0);

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= 2'd0;
            r_need <= 2'd0;
            r_acc  <= '0;
        end else if (fire) begin
            r_pc   <= n_pc;
            r_need <= n_need;
            r_acc  <= n_acc;
        end
    end

    // held bytes
    always_ff @(posedge i_clk) begin
        if (fire && pend_we) begin
            r_pend[pend_idx] <= b;
        end
    end

endmodule

// ===== design/uvr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// uvr_cmd_fifo - command queue
// small register queue between scanner and byte expander
// ----------------------------------------------------------------------------
module uvr_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  uvr_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output uvr_pkg::t_cmd o_head
);
    import uvr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

endmodule

// ===== design/uvr_back.sv =====
// ----------------------------------------------------------------------------
// uvr_back - byte expander
// walks each command into the output register, one byte per unstalled cycle
// ----------------------------------------------------------------------------
module uvr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  uvr_pkg::t_cmd i_head,
    output logic          o_pop,
    uvr_out_if.source     o_out
);
    import uvr_pkg::*;

    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_end;
    logic       r_sub;
    logic       r_any;
    logic [2:0] r_fpos;
    logic [1:0] r_k;
    logic [1:0] r_rpos;
    logic       r_rep;

    logic       load;
    logic       take;
    logic       sub_phase;
    logic [7:0] cur_byte;
    logic       cur_final;

    assign load      = !r_ov || o_out.ready;
    assign take      = load && !i_empty;
    assign sub_phase = r_fpos < i_head.fffd_cnt;
    assign o_pop     = take && cur_final;

    // pick the current byte of the command
    always_comb begin
        cur_byte = i_head.raw_bytes[r_rpos];
        if (sub_phase) begin
            unique case (r_k)
                2'd0:    cur_byte = FFFD_B0;
                2'd1:    cur_byte = FFFD_B1;
                default: cur_byte = FFFD_B2;
            endcase
        end
    end

    // last byte of the command
    always_comb begin
        if (sub_phase) begin
            cur_final = r_k == 2'd2 && (r_fpos + 3'd1) == i_head.fffd_cnt
                        && i_head.raw_cnt == 3'd0;
        end else begin
            cur_final = ({1'b0, r_rpos} + 3'd1) == i_head.raw_cnt;
        end
    end

    // control: valid, position counters, sticky flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_fpos <= 3'd0;
            r_k    <= 2'd0;
            r_rpos <= 2'd0;
            r_rep  <= 1'b0;
        end else if (load) begin
            r_ov <= !i_empty;
            if (take) begin
                r_rep <= (cur_final && i_head.str_last) ? 1'b0 : (r_rep || sub_phase);
                if (cur_final) begin
                    r_fpos <= 3'd0;
                    r_k    <= 2'd0;
                    r_rpos <= 2'd0;
                end else if (sub_phase) begin
                    if (r_k == 2'd2) begin
                        r_k    <= 2'd0;
                        r_fpos <= r_fpos + 3'd1;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end else begin
                    r_rpos <= r_rpos + 2'd1;
                end
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= cur_byte;
            r_last <= cur_final;
            r_end  <= cur_final && i_head.str_last;
            r_sub  <= sub_phase;
            r_any  <= r_rep || sub_phase;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.out_byte      = r_byte;
    assign o_out.out_last      = r_last;
    assign o_out.string_end    = r_end;
    assign o_out.is_substitute = r_sub;
    assign o_out.any_replaced  = r_any;

endmodule

// ===== design/uvr_checker.sv =====
// ----------------------------------------------------------------------------
// uvr_checker - port checks
// watches the output channel of the top level over time
// ----------------------------------------------------------------------------
`include "utf8_validate_repair_defines.svh"

module uvr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_byte,
    input logic       i_last,
    input logic       i_end,
    input logic       i_sub,
    input logic       i_any
);
    import uvr_pkg::*;

    // stalled output byte holds
    `UVR_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_byte), "stalled output changed")

    // string end closes the request's bytes
    `UVR_ASSERT_IMPLY(a_end_last, i_clk, i_rst_n, i_valid && i_end, i_last, "string_end without out_last")

    // a substitute byte sets the sticky flag
    `UVR_ASSERT_IMPLY(a_sub_any, i_clk, i_rst_n, i_valid && i_sub, i_any, "substitute without any_replaced")

    // substitute bytes come from U+FFFD only
    `UVR_ASSERT_IMPLY(a_sub_byte, i_clk, i_rst_n, i_valid && i_sub, i_byte == FFFD_B0 || i_byte == FFFD_B1 || i_byte == FFFD_B2, "bad substitute byte")

endmodule

bind utf8_validate_repair uvr_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_byte  (o_out.out_byte),
    .i_last  (o_out.out_last),
    .i_end   (o_out.string_end),
    .i_sub   (o_out.is_substitute),
    .i_any   (o_out.any_replaced)
);

// ===== verif/utf8_validate_repair_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validate_repair_checker - output predictor and comparator
// watches both channels, rebuilds the repaired utf-8 stream for every raw
// request and compares each output byte, in order, against the prediction
// ----------------------------------------------------------------------------
module utf8_validate_repair_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    uvr_in_if    i_raw,
    uvr_out_if   i_fixed,
    output int   o_mismatches,
    output int   o_outstanding
);
    import uvr_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       str_end;
        logic       subst;
        logic       replaced;
    } t_fixed_byte;

    // predicted output bytes still to arrive, oldest first
    t_fixed_byte fixed_q[$];
    // bytes made by the request being predicted
    t_fixed_byte burst[$];

    // held sequence and sticky flag
    logic [7:0]  held [3];
    logic [1:0]  held_cnt;
    logic [1:0]  cont_need;
    logic [20:0] cp_acc;
    logic        sticky;
    int          err_cnt;

    // legal code point for the given number of continuation bytes
    function automatic logic cp_legal(input logic [1:0] n, input logic [20:0] cp);
        logic ok;
        ok = 1'b1;
        if (n == 2'd1 && cp < MIN_CP2) ok = 1'b0;
        if (n == 2'd2 && cp < MIN_CP3) ok = 1'b0;
        if (n == 2'd3 && cp < MIN_CP4) ok = 1'b0;
        if (cp > MAX_CP) ok = 1'b0;
        if (cp >= SURR_LO && cp <= SURR_HI) ok = 1'b0;
        return ok;
    endfunction

    task automatic emit(input logic [7:0] b, input logic subst);
        t_fixed_byte r;
        if (subst) sticky = 1'b1;
        r.data     = b;
        r.last     = 1'b0;
        r.str_end  = 1'b0;
        r.subst    = subst;
        r.replaced = sticky;
        burst.insert(burst.size(), r);
    endtask

    task automatic emit_fffd();
        emit(FFFD_B0, 1'b1);
        emit(FFFD_B1, 1'b1);
        emit(FFFD_B2, 1'b1);
    endtask

    task automatic clear_seq();
        held_cnt  = 2'd0;
        cont_need = 2'd0;
        cp_acc    = '0;
    endtask

    // every held byte turns into one replacement character
    task automatic flush_held();
        for (int k = 0; k < held_cnt; k++) emit_fffd();
        clear_seq();
    endtask

    // byte seen with nothing held
    task automatic scan_lead(input logic [7:0] b);
        if (b < 8'h80) begin
            emit(b, 1'b0);
        end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
            held[0] = b; held_cnt = 2'd1; cont_need = 2'd1; cp_acc = {16'd0, b[4:0]};
        end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
            held[0] = b; held_cnt = 2'd1; cont_need = 2'd2; cp_acc = {17'd0, b[3:0]};
        end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
            held[0] = b; held_cnt = 2'd1; cont_need = 2'd3; cp_acc = {18'd0, b[2:0]};
        end else begin
            emit_fffd();
        end
    endtask

    task automatic scan_byte(input logic [7:0] b);
        if (held_cnt == 2'd0) begin
            scan_lead(b);
        end else if ((b & CONT_MASK) != CONT_VAL) begin
            // sequence broken by a non-continuation byte
            flush_held();
            scan_lead(b);
        end else begin
            cp_acc = {cp_acc[14:0], b[5:0]};
            if (held_cnt >= cont_need) begin
                if (cp_legal(cont_need, cp_acc)) begin
                    for (int k = 0; k < held_cnt; k++) emit(held[k], 1'b0);
                    emit(b, 1'b0);
                end else begin
                    // overlong, surrogate or out of range: one U+FFFD per byte
                    for (int k = 0; k <= held_cnt; k++) emit_fffd();
                end
                clear_seq();
            end else if (held_cnt < 2'd3) begin
                held[held_cnt] = b;
                held_cnt = held_cnt + 2'd1;
            end else begin
                flush_held();
            end
        end
    endtask

    // predict the output bytes of one raw request
    task automatic repair_request(input logic [7:0] b, input logic last);
        burst.delete();
        scan_byte(b);
        if (last) flush_held();
        if (burst.size() > 0) begin
            burst[burst.size() - 1].last    = 1'b1;
            burst[burst.size() - 1].str_end = last;
        end
        foreach (burst[k]) fixed_q.insert(fixed_q.size(), burst[k]);
        if (last) sticky = 1'b0;
    endtask

    // compare accepted output bytes, then predict from accepted requests
    always @(posedge i_clk) begin
        t_fixed_byte got;
        t_fixed_byte want;
        if (!i_rst_n) begin
            fixed_q.delete();
            clear_seq();
            sticky  = 1'b0;
            err_cnt = 0;
        end else begin
            if (i_fixed.valid && i_fixed.ready) begin
                got.data     = i_fixed.out_byte;
                got.last     = i_fixed.out_last;
                got.str_end  = i_fixed.string_end;
                got.subst    = i_fixed.is_substitute;
                got.replaced = i_fixed.any_replaced;
                if (fixed_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected output byte %h last %b end %b sub %b rep %b",
                             $time, got.data, got.last, got.str_end, got.subst,
                             got.replaced);
                end else begin
                    want = fixed_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        $display({"%0t: mismatch expected byte %h last %b end %b sub %b",
                                  " rep %b, actual byte %h last %b end %b sub %b rep %b"},
                                 $time, want.data, want.last, want.str_end, want.subst,
                                 want.replaced, got.data, got.last, got.str_end,
                                 got.subst, got.replaced);
                    end
                end
            end
            if (i_raw.valid && i_raw.ready) repair_request(i_raw.in_byte, i_raw.in_last);
        end
        o_mismatches  <= err_cnt;
        o_outstanding <= fixed_q.size();
    end

endmodule

// ===== verif/utf8_validate_repair_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validate_repair_test - testbench top
// drives directed and random utf-8 strings with varying idle and stall
// patterns, a long receiver hold-off and drain pauses; verdict from checker
// ----------------------------------------------------------------------------
module utf8_validate_repair_test;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 80;

    logic i_clk;
    logic i_rst_n;

    uvr_in_if  raw_ch ();
    uvr_out_if fixed_ch ();

    int  mismatches;
    int  outstanding;
    int  sender_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    int  sent;
    int  quiet_cycles;

    logic [7:0] text_q[$];

    utf8_validate_repair uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (raw_ch),
        .o_out   (fixed_ch)
    );

    utf8_validate_repair_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_raw         (raw_ch),
        .i_fixed       (fixed_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // receiver: random stalls, or a long hold-off on request
    initial begin
        fixed_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                fixed_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                fixed_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (raw_ch.valid && raw_ch.ready) || (fixed_ch.valid && fixed_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one raw byte and wait until it is taken
    task automatic offer_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            raw_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        raw_ch.valid   <= 1'b1;
        raw_ch.in_byte <= b;
        raw_ch.in_last <= last;
        do @(posedge i_clk); while (!raw_ch.ready);
        sent++;
    endtask

    // sender pauses until every predicted byte has come out
    task automatic drain();
        raw_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'hBF, 8'h80));
    endfunction

    // append one byte to the string being built
    task automatic add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    // append one character, mostly well formed, sometimes broken or noise
    task automatic append_char();
        int         kind;
        logic [7:0] lead;
        int         need;
        kind = $urandom_range(99);
        if (kind < 35) begin
            add_byte(8'($urandom_range(8'h7F)));
        end else if (kind < 47) begin
            add_byte(8'($urandom_range(8'hDF, 8'hC2)));
            add_byte(cont_byte());
        end else if (kind < 59) begin
            lead = 8'($urandom_range(8'hEF, 8'hE0));
            add_byte(lead);
            if (lead == 8'hE0)      add_byte(8'($urandom_range(8'hBF, 8'hA0)));
            else if (lead == 8'hED) add_byte(8'($urandom_range(8'h9F, 8'h80)));
            else                    add_byte(cont_byte());
            add_byte(cont_byte());
        end else if (kind < 69) begin
            lead = 8'($urandom_range(8'hF4, 8'hF0));
            add_byte(lead);
            if (lead == 8'hF0)      add_byte(8'($urandom_range(8'hBF, 8'h90)));
            else if (lead == 8'hF4) add_byte(8'($urandom_range(8'h8F, 8'h80)));
            else                    add_byte(cont_byte());
            add_byte(cont_byte());
            add_byte(cont_byte());
        end else if (kind < 77) begin
            // truncated sequence
            lead = 8'($urandom_range(8'hF4, 8'hC2));
            need = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
            add_byte(lead);
            repeat ($urandom_range(need - 1)) add_byte(cont_byte());
        end else if (kind < 85) begin
            // complete but overlong, surrogate or above the code space
            case ($urandom_range(5))
                0: begin
                    add_byte(8'hC0 | 8'($urandom_range(1)));
                    add_byte(cont_byte());
                end
                1: begin
                    add_byte(8'hE0);
                    add_byte(8'($urandom_range(8'h9F, 8'h80)));
                    add_byte(cont_byte());
                end
                2: begin
                    add_byte(8'hED);
                    add_byte(8'($urandom_range(8'hBF, 8'hA0)));
                    add_byte(cont_byte());
                end
                3: begin
                    add_byte(8'hF0);
                    add_byte(8'($urandom_range(8'h8F, 8'h80)));
                    add_byte(cont_byte());
                    add_byte(cont_byte());
                end
                4: begin
                    add_byte(8'hF4);
                    add_byte(8'($urandom_range(8'hBF, 8'h90)));
                    add_byte(cont_byte());
                    add_byte(cont_byte());
                end
                default: begin
                    add_byte(8'($urandom_range(8'hF7, 8'hF5)));
                    repeat (3) add_byte(cont_byte());
                end
            endcase
        end else begin
            add_byte(8'($urandom_range(8'hFF)));
        end
    endtask

    // build and send one string, last flag on its final byte
    task automatic offer_string();
        int n;
        n = $urandom_range(10, 1);
        text_q.delete();
        repeat (n) append_char();
        foreach (text_q[k]) offer_byte(text_q[k], k == text_q.size() - 1);
    endtask

    // stimulus
    initial begin
        i_rst_n         <= 1'b0;
        raw_ch.valid    <= 1'b0;
        raw_ch.in_byte  <= 8'h00;
        raw_ch.in_last  <= 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_req        = 1'b0;
        sent            = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ascii extremes
        offer_byte(8'h00, 1'b0);
        offer_byte(8'h7F, 1'b0);
        // two-byte extremes
        offer_byte(8'hC2, 1'b0);
        offer_byte(8'h80, 1'b0);
        offer_byte(8'hDF, 1'b0);
        offer_byte(8'hBF, 1'b0);
        // overlong two-byte form
        offer_byte(8'hC0, 1'b0);
        offer_byte(8'h80, 1'b0);
        // surrogate
        offer_byte(8'hED, 1'b0);
        offer_byte(8'hA0, 1'b0);
        offer_byte(8'h80, 1'b0);
        // highest legal code point
        offer_byte(8'hF4, 1'b0);
        offer_byte(8'h8F, 1'b0);
        offer_byte(8'hBF, 1'b0);
        offer_byte(8'hBF, 1'b0);
        // just above the code space
        offer_byte(8'hF4, 1'b0);
        offer_byte(8'h90, 1'b0);
        offer_byte(8'h80, 1'b0);
        offer_byte(8'h80, 1'b0);
        // bytes that cannot start a sequence
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h80, 1'b0);
        // sequence broken by an ascii byte
        offer_byte(8'hE2, 1'b0);
        offer_byte(8'h41, 1'b0);
        // string ends with bytes held
        offer_byte(8'hF0, 1'b0);
        offer_byte(8'h9F, 1'b1);
        drain();

        // random strings under each idle pattern
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin sender_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            while (sent < 25 + PHASE_ITEMS * (p + 1)) offer_string();
            drain();
        end

        // long receiver hold-off while the sender keeps offering
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_req        = 1'b1;
        while (hold_req) offer_string();
        drain();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== utf8_validate_repair.f =====
+incdir+design
design/uvr_pkg.sv
design/uvr_in_if.sv
design/uvr_out_if.sv
design/uvr_front.sv
design/uvr_cmd_fifo.sv
design/uvr_back.sv
design/utf8_validate_repair.sv
design/uvr_checker.sv
verif/utf8_validate_repair_checker.sv
verif/utf8_validate_repair_test.sv
